// ----- rtl/shs_pkg.sv -----
package shs_pkg;

    localparam int unsigned BLOCK_BITS = 512;
    localparam int unsigned WORD_BITS  = 32;
    localparam int unsigned ROUNDS     = 64;

    localparam logic [5:0] FILL_LAST    = 6'd63;
    localparam logic [5:0] FILL_PAD_END = 6'd56;
    localparam logic [7:0] PAD_BYTE     = 8'h80;
    localparam logic [5:0] ROUND_LAST   = 6'd63;
    localparam logic [2:0] WORD_LAST    = 3'd7;

    localparam logic [0:0] MODE_ABSORB = 1'b0;
    localparam logic [0:0] MODE_FINISH = 1'b1;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_COMPRESS  = 7'b0000010,
        ST_FOLD      = 7'b0000100,
        ST_PAD_FIRST = 7'b0001000,
        ST_PAD_ZERO  = 7'b0010000,
        ST_PAD_LEN   = 7'b0100000,
        ST_EMIT      = 7'b1000000
    } state_t;

    typedef enum logic [1:0] {
        BYTE_IN   = 2'd0,
        BYTE_PAD  = 2'd1,
        BYTE_ZERO = 2'd2,
        BYTE_LEN  = 2'd3
    } byte_sel_t;

    typedef struct packed {
        logic      push;
        byte_sel_t byte_sel;
        logic      count_len;
        logic      load_work;
        logic      round_en;
        logic [5:0] round_idx;
        logic      fold;
        logic      clear;
        logic [2:0] word_idx;
    } cmd_t;

    typedef struct packed {
        logic fill_last;
        logic fill_pad_end;
    } status_t;

endpackage

// ----- rtl/shs_ctrl.sv -----
module shs_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  logic             in_mode,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  shs_pkg::status_t status,
    output shs_pkg::cmd_t    cmd
);

    shs_pkg::state_t state_reg, state_next;
    shs_pkg::state_t ret_reg, ret_next;
    logic [5:0] round_reg, round_next;
    logic [2:0] word_reg, word_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= shs_pkg::ST_IDLE;
            ret_reg   <= shs_pkg::ST_IDLE;
            round_reg <= '0;
            word_reg  <= '0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            round_reg <= round_next;
            word_reg  <= word_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        round_next    = round_reg;
        word_next     = word_reg;
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        cmd           = '0;
        cmd.byte_sel  = shs_pkg::BYTE_IN;
        cmd.round_idx = round_reg;
        cmd.word_idx  = word_reg;

        case (state_reg)
            shs_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (in_mode == shs_pkg::MODE_FINISH) begin
                        state_next = shs_pkg::ST_PAD_FIRST;
                    end else begin
                        cmd.push      = 1'b1;
                        cmd.count_len = 1'b1;
                        if (status.fill_last) begin
                            cmd.load_work = 1'b1;
                            ret_next      = shs_pkg::ST_IDLE;
                            state_next    = shs_pkg::ST_COMPRESS;
                        end
                    end
                end
            end
            shs_pkg::ST_PAD_FIRST: begin
                cmd.push     = 1'b1;
                cmd.byte_sel = shs_pkg::BYTE_PAD;
                state_next   = shs_pkg::ST_PAD_ZERO;
                if (status.fill_last) begin
                    cmd.load_work = 1'b1;
                    ret_next      = shs_pkg::ST_PAD_ZERO;
                    state_next    = shs_pkg::ST_COMPRESS;
                end
            end
            shs_pkg::ST_PAD_ZERO: begin
                if (status.fill_pad_end) begin
                    state_next = shs_pkg::ST_PAD_LEN;
                end else begin
                    cmd.push     = 1'b1;
                    cmd.byte_sel = shs_pkg::BYTE_ZERO;
                    if (status.fill_last) begin
                        cmd.load_work = 1'b1;
                        ret_next      = shs_pkg::ST_PAD_ZERO;
                        state_next    = shs_pkg::ST_COMPRESS;
                    end
                end
            end
            shs_pkg::ST_PAD_LEN: begin
                cmd.push     = 1'b1;
                cmd.byte_sel = shs_pkg::BYTE_LEN;
                if (status.fill_last) begin
                    cmd.load_work = 1'b1;
                    ret_next      = shs_pkg::ST_EMIT;
                    state_next    = shs_pkg::ST_COMPRESS;
                end
            end
            shs_pkg::ST_COMPRESS: begin
                cmd.round_en = 1'b1;
                round_next   = round_reg + 6'd1;
                if (round_reg == shs_pkg::ROUND_LAST) begin
                    state_next = shs_pkg::ST_FOLD;
                end
            end
            shs_pkg::ST_FOLD: begin
                cmd.fold   = 1'b1;
                state_next = ret_reg;
            end
            shs_pkg::ST_EMIT: begin
                out_valid = 1'b1;
                if (out_ready) begin
                    word_next = word_reg + 3'd1;
                    if (word_reg == shs_pkg::WORD_LAST) begin
                        // digest gone: back to the initial hash state
                        cmd.clear  = 1'b1;
                        state_next = shs_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = shs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/shs_datapath.sv -----
module shs_datapath (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [7:0]       in_byte,
    input  shs_pkg::cmd_t    cmd,
    output shs_pkg::status_t status,
    output logic [31:0]      digest_word
);

    localparam int unsigned BB = shs_pkg::BLOCK_BITS;

    // window holds 16 schedule words, oldest at the top
    logic [BB-1:0] window_reg, window_next;
    logic [31:0]   chain_reg [8];
    logic [31:0]   work_reg  [8];
    logic [63:0]   len_reg;
    logic [5:0]    fill_reg;

    logic [7:0]  push_byte;
    logic [31:0] w_cur, w_1, w_9, w_14, w_new;
    logic [31:0] a, e, t1, t2, big0, big1, ch, maj;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    assign status.fill_last    = (fill_reg == shs_pkg::FILL_LAST);
    assign status.fill_pad_end = (fill_reg == shs_pkg::FILL_PAD_END);
    assign digest_word         = chain_reg[cmd.word_idx];

    always_comb begin
        case (cmd.byte_sel)
            shs_pkg::BYTE_IN:   push_byte = in_byte;
            shs_pkg::BYTE_PAD:  push_byte = shs_pkg::PAD_BYTE;
            shs_pkg::BYTE_ZERO: push_byte = 8'h00;
            // length goes out most significant byte first
            shs_pkg::BYTE_LEN:  push_byte = len_reg[{~fill_reg[2:0], 3'b000} +: 8];
            default:            push_byte = 8'h00;
        endcase
    end

    assign w_cur = window_reg[BB-1      -: 32];
    assign w_1   = window_reg[BB-1-32   -: 32];
    assign w_9   = window_reg[BB-1-288  -: 32];
    assign w_14  = window_reg[BB-1-448  -: 32];
    assign w_new = w_cur
                 + (rotr(w_1, 7) ^ rotr(w_1, 18) ^ (w_1 >> 3))
                 + w_9
                 + (rotr(w_14, 17) ^ rotr(w_14, 19) ^ (w_14 >> 10));

    assign a    = work_reg[0];
    assign e    = work_reg[4];
    assign big1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
    assign ch   = (e & work_reg[5]) ^ (~e & work_reg[6]);
    assign t1   = work_reg[7] + big1 + ch + shs_pkg::ROUND_K[cmd.round_idx] + w_cur;
    assign big0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
    assign maj  = (a & work_reg[1]) ^ (a & work_reg[2]) ^ (work_reg[1] & work_reg[2]);
    assign t2   = big0 + maj;

    always_comb begin
        window_next = window_reg;
        if (cmd.push) begin
            window_next = {window_reg[BB-9:0], push_byte};
        end else if (cmd.round_en) begin
            window_next = {window_reg[BB-33:0], w_new};
        end
    end

    always_ff @(posedge aclk) begin
        window_reg <= window_next;
        if (cmd.load_work) begin
            work_reg <= chain_reg;
        end else if (cmd.round_en) begin
            work_reg[0] <= t1 + t2;
            work_reg[1] <= work_reg[0];
            work_reg[2] <= work_reg[1];
            work_reg[3] <= work_reg[2];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[5] <= work_reg[4];
            work_reg[6] <= work_reg[5];
            work_reg[7] <= work_reg[6];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_reg <= shs_pkg::INIT_H;
            len_reg   <= '0;
            fill_reg  <= '0;
        end else begin
            if (cmd.clear) begin
                chain_reg <= shs_pkg::INIT_H;
                len_reg   <= '0;
                fill_reg  <= '0;
            end else begin
                if (cmd.fold) begin
                    for (int i = 0; i < 8; i++) begin
                        chain_reg[i] <= chain_reg[i] + work_reg[i];
                    end
                end
                if (cmd.count_len) begin
                    len_reg <= len_reg + 64'd8;
                end
                if (cmd.push) begin
                    fill_reg <= fill_reg + 6'd1;
                end
            end
        end
    end

endmodule

// ----- rtl/sha256_stream_hasher_core.sv -----
// SHA-256 over a byte stream.
// Slave channel: one transaction per byte. s_tuser = 0 appends s_tdata to the
// message; s_tuser = 1 finishes the message (s_tdata ignored).
// Master channel: after a finish, eight transactions carry the digest words,
// word 0 first, big-endian; m_tlast marks the eighth.
// Flow: an absorb byte is taken while idle; the byte that completes a 64-byte
// block is followed by a compression (64 rounds on the single round unit, then
// a fold step) before the next byte is taken. A finish starts the padding:
// one padding byte per cycle (9 to 72 bytes) while no block is compressed,
// a step without a byte before the length bytes, one or two compressions, and
// then the digest words.
// s_tready is high only while the core is idle; one item is in work at a time.
// A stalled receiver holds the current digest word on m_tdata; the core
// waits and takes no input until all eight words are delivered, after which
// it is ready for a new message from the initial hash values.
// Reset (aresetn low, synchronous) loads the initial hash values and clears
// the bit count and block fill; the core is ready in the next cycle.
module sha256_stream_hasher_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, [39:35] zero
    output logic        m_tlast    // last_word
);

    shs_pkg::cmd_t    cmd;
    shs_pkg::status_t status;
    logic [31:0]      digest_word;

    shs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_mode   (s_tuser),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    shs_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_byte     (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .digest_word (digest_word)
    );

    assign m_tdata = {5'b00000, cmd.word_idx, digest_word};
    assign m_tlast = (cmd.word_idx == shs_pkg::WORD_LAST);

endmodule
